// File: rtl/core/twst_pkg.sv
package twst_pkg;

    localparam int MAX_WINDOWS_DEF = 8;
    localparam int SEC_W           = 17;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FIELD = 3'd1;
    localparam logic [2:0] ST_ORDER     = 3'd2;
    localparam logic [2:0] ST_OVERLAP   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [5:0] HOUR_MAX  = 6'd23;
    localparam logic [5:0] FIELD_MAX = 6'd60;

    localparam logic [SEC_W-1:0] SEC_PER_HOUR = SEC_W'(3600);
    localparam logic [SEC_W-1:0] SEC_PER_MIN  = SEC_W'(60);

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] on_hour;
        logic [5:0] on_minute;
        logic [5:0] on_second;
        logic [5:0] off_hour;
        logic [5:0] off_minute;
        logic [5:0] off_second;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       active;
        logic [3:0] window_count;
    } t_out_item;

    typedef struct packed {
        logic [SEC_W-1:0] start_sec;
        logic [SEC_W-1:0] stop_sec;
    } t_window;

    typedef struct packed {
        logic [SEC_W-1:0] lo;
        logic [SEC_W-1:0] hi;
    } t_probe;

    function automatic logic [SEC_W-1:0] day_secs(input logic [5:0] h,
                                                  input logic [5:0] m,
                                                  input logic [5:0] s);
        return SEC_W'(h) * SEC_PER_HOUR + SEC_W'(m) * SEC_PER_MIN + SEC_W'(s);
    endfunction

    function automatic logic field_bad(input logic [5:0] h,
                                       input logic [5:0] m,
                                       input logic [5:0] s);
        return (h > HOUR_MAX) || (m > FIELD_MAX) || (s > FIELD_MAX);
    endfunction

endpackage

// File: rtl/core/time_window_schedule_table.sv
// Daily on/off window table. Each command (clear, add, query) returns one result item.
// An item is converted to seconds of the day as it is taken and checked in the next cycle;
// for a valid add or a query, the stored windows (at most MAX_WINDOWS) are then walked one
// per cycle through a single interval comparator reading the window memory, and an add
// that clears the walk then checks for room and writes. The result waits in its output
// register until taken. No new item is accepted until the result is taken. Window
// storage needs no clearing after reset.
module time_window_schedule_table #(
    parameter int MAX_WINDOWS = twst_pkg::MAX_WINDOWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  twst_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output twst_pkg::t_out_item o_item
);
    import twst_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOWS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHK    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state           r_state,  n_state;
    logic [1:0]       r_cmd,    n_cmd;
    logic [SEC_W-1:0] r_lo,     n_lo;
    logic [SEC_W-1:0] r_hi,     n_hi;
    logic             r_bad,    n_bad;
    logic [CNT_W-1:0] r_idx,    n_idx;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [2:0]       r_status, n_status;
    logic             r_active, n_active;

    logic             accept_in;
    logic [SEC_W-1:0] on_s, off_s, now_s;
    logic             in_bad;
    logic [CNT_W-1:0] idx_inc;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    t_window          rd_data;
    t_window          wr_data;
    t_probe           probe;
    logic             hit;
    logic [CNT_W+3:0] cnt_ext;

    assign accept_in = i_valid && o_ready;
    assign on_s      = day_secs(i_item.on_hour, i_item.on_minute, i_item.on_second);
    assign off_s     = day_secs(i_item.off_hour, i_item.off_minute, i_item.off_second);
    assign now_s     = day_secs({1'b0, i_item.now_hour}, i_item.now_minute,
                                i_item.now_second);
    assign in_bad    = field_bad(i_item.on_hour, i_item.on_minute, i_item.on_second) ||
                       field_bad(i_item.off_hour, i_item.off_minute, i_item.off_second);
    assign idx_inc   = r_idx + CNT_W'(1);

    assign probe.lo          = r_lo;
    assign probe.hi          = r_hi;
    assign wr_data.start_sec = r_lo;
    assign wr_data.stop_sec  = r_hi;
    assign rd_addr           = (n_idx < CNT_MAX) ? n_idx[IDX_W-1:0] : '0;

    twst_mem #(
        .DEPTH(MAX_WINDOWS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    twst_match u_match (
        .i_probe (probe),
        .i_entry (rd_data),
        .o_hit   (hit)
    );

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_bad    = r_bad;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        n_active = r_active;
        wr_en    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_cmd    = i_item.cmd;
                    n_bad    = in_bad;
                    n_idx    = '0;
                    n_status = ST_OK;
                    n_active = 1'b0;
                    n_state  = S_CHK;
                    if (i_item.cmd == CMD_QUERY) begin
                        n_lo = now_s;
                        n_hi = now_s + SEC_W'(1);
                    end else begin
                        n_lo = on_s;
                        n_hi = off_s;
                    end
                end
            end
            S_CHK: begin
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    CMD_ADD: begin
                        if (r_bad) begin
                            n_status = ST_BAD_FIELD;
                        end else if (r_hi <= r_lo) begin
                            n_status = ST_ORDER;
                        end else if (r_count == '0) begin
                            n_state = S_COMMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_QUERY: begin
                        if (r_count != '0) begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_DONE;
                    if (r_cmd == CMD_ADD) begin
                        n_status = ST_OVERLAP;
                    end else begin
                        n_active = 1'b1;
                    end
                end else if (idx_inc == r_count) begin
                    n_state = (r_cmd == CMD_ADD) ? S_COMMIT : S_DONE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_COMMIT: begin
                n_state = S_DONE;
                if (r_count == CNT_MAX) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_bad    <= n_bad;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_active <= n_active;
    end

    assign cnt_ext             = {4'b0, r_count};
    assign o_ready             = (r_state == S_IDLE);
    assign o_valid             = (r_state == S_DONE);
    assign o_item.status       = r_status;
    assign o_item.active       = r_active;
    assign o_item.window_count = cnt_ext[3:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("window count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == '0) || (r_count == $past(r_count) + CNT_W'(1)))
        else $error("window count moved by more than one");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status == ST_FULL) |-> (r_count == CNT_MAX))
        else $error("full status with room left");

    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_count))
        else $error("scan index past stored windows");

    a_write_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (o_valid && o_item.status == ST_OK))
        else $error("window written without ok status");

endmodule

// File: rtl/core/twst_mem.sv
module twst_mem #(
    parameter int DEPTH = twst_pkg::MAX_WINDOWS_DEF,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  twst_pkg::t_window  i_wr_data,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output twst_pkg::t_window  o_rd_data
);
    import twst_pkg::*;

    t_window r_mem [DEPTH];
    t_window r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/twst_match.sv
module twst_match (
    input  twst_pkg::t_probe  i_probe,
    input  twst_pkg::t_window i_entry,
    output logic              o_hit
);
    import twst_pkg::*;

    // half-open intervals [lo, hi) and [start, stop) intersect
    assign o_hit = (i_entry.start_sec < i_probe.hi) && (i_probe.lo < i_entry.stop_sec);

endmodule
